>>> rtl/acc_scr_pkg.sv
// Package for the accelerometer sample correct and remap block.
// Holds the register indexes, gravity modes, field widths, constants and the matrix term helper.
// No dependencies.
package acc_scr_pkg;

   // Field widths
   localparam int SampleWidth = 16;
   localparam int CorrWidth   = 18;  // sample after offset and gravity correction
   localparam int SumWidth    = 19;  // one row of the remap
   localparam int AccelWidth  = 29;
   localparam int ProdWidth   = AccelWidth + 1;
   localparam int OneGWidth   = 12;
   localparam int MatrixWidth = 18;
   localparam int CsrIdxWidth = 3;

   // Constants of the correction
   localparam logic signed [CorrWidth-1:0] DeadZone = CorrWidth'(50);
   localparam logic signed [ProdWidth-1:0] Scale    = ProdWidth'(981);

   // Configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_OFFSET_X    = 3'd0,
      CSR_OFFSET_Y    = 3'd1,
      CSR_OFFSET_Z    = 3'd2,
      CSR_GRAVITY     = 3'd3,
      CSR_ONE_G       = 3'd4,
      CSR_ORIENTATION = 3'd5
   } csr_index_type;

   // z gravity correction modes
   typedef enum logic [1:0] {
      GRAV_NONE = 2'd0,
      GRAV_SUB  = 2'd1,
      GRAV_ADD  = 2'd2
   } gravity_mode_type;

   // Matrix entry codes
   typedef enum logic [1:0] {
      ENTRY_ZERO = 2'b00,
      ENTRY_PLUS = 2'b01,
      ENTRY_MINUS = 2'b11
   } entry_code_type;

   localparam logic [MatrixWidth-1:0] MatrixIdentity = 18'h10101;
   localparam logic [OneGWidth-1:0]   OneGReset      = 12'd1024;

   // One term of a remap row: +v, -v or zero; the meaningless code acts as zero
   function automatic logic signed [CorrWidth-1:0] matrix_term(
      input logic [1:0]                  code,
      input logic signed [CorrWidth-1:0] value
   );
      logic signed [CorrWidth-1:0] term;
      case (entry_code_type'(code))
         ENTRY_PLUS:  term = value;
         ENTRY_MINUS: term = -value;
         default:     term = '0;
      endcase
      return term;
   endfunction

endpackage

>>> rtl/accel_sample_correct_and_remap_top.sv
// Top level of the accelerometer sample correct and remap block.
// Four-stage pipeline; depends on acc_scr_pkg.
//
// Usage:
//  - Input: raise start with the six raw bytes on req_*; a frame is taken at
//    every clock edge with start high and busy low. busy stays low, so a
//    frame may be offered in every cycle.
//  - Output: rsp_valid is high for one cycle with accel_x/y/z on rsp_*.
//    Each frame gives exactly one result word once it has passed all the
//    pipeline stages; frames leave in the order they arrive.
//  - Throughput: one frame per cycle. The stages are offset and gravity
//    correction, dead zone, remap sums and the multiply by 981.
//  - Configuration: csr_valid with csr_index and csr_wdata; csr_ready is
//    always high. Write only while no frame is in flight. Unknown indexes
//    are dropped.
//  - Reset (synchronous, active high): empties the pipeline and returns the
//    registers to zero offsets, no gravity correction, 1024 counts per g and
//    the identity orientation.
//  - The receiver cannot stall; no result is ever held back.
module accel_sample_correct_and_remap_top
   import acc_scr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [7:0]             req_x_low_byte,
   input  logic [7:0]             req_x_high_byte,
   input  logic [7:0]             req_y_low_byte,
   input  logic [7:0]             req_y_high_byte,
   input  logic [7:0]             req_z_low_byte,
   input  logic [7:0]             req_z_high_byte,
   output logic                   rsp_valid,
   output logic signed [AccelWidth-1:0] rsp_accel_x,
   output logic signed [AccelWidth-1:0] rsp_accel_y,
   output logic signed [AccelWidth-1:0] rsp_accel_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [MatrixWidth-1:0] csr_wdata
);

   // Configuration registers
   logic signed [SampleWidth-1:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [1:0]                    gravity_ff;
   logic [OneGWidth-1:0]          one_g_ff;
   logic [MatrixWidth-1:0]        matrix_ff;

   // Pipeline registers
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [CorrWidth-1:0]   s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [CorrWidth-1:0]   s2_x_ff, s2_y_ff, s2_z_ff;
   logic signed [SumWidth-1:0]    s3_sum_ff [3];
   logic signed [AccelWidth-1:0]  s4_acc_ff [3];

   // Next values
   logic                          accept_in;
   logic signed [CorrWidth-1:0]   s1_x_in, s1_y_in, s1_z_in;
   logic signed [CorrWidth-1:0]   s2_x_in, s2_y_in;
   logic signed [SumWidth-1:0]    s3_sum_in [3];
   logic signed [AccelWidth-1:0]  s4_acc_in [3];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept_in = start && !busy;

   // Write configuration words
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         gravity_ff  <= GRAV_NONE;
         one_g_ff    <= OneGReset;
         matrix_ff   <= MatrixIdentity;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_X:    offset_x_ff <= csr_wdata[SampleWidth-1:0];
            CSR_OFFSET_Y:    offset_y_ff <= csr_wdata[SampleWidth-1:0];
            CSR_OFFSET_Z:    offset_z_ff <= csr_wdata[SampleWidth-1:0];
            CSR_GRAVITY:     gravity_ff  <= csr_wdata[1:0];
            CSR_ONE_G:       one_g_ff    <= csr_wdata[OneGWidth-1:0];
            CSR_ORIENTATION: matrix_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: merge bytes, double and wrap, remove offsets, apply gravity to z
   always_comb begin
      logic signed [SampleWidth-1:0] raw_x, raw_y, raw_z;
      logic signed [CorrWidth-1:0]   two_g, z_off;
      raw_x   = {req_x_high_byte[6:0], req_x_low_byte, 1'b0};
      raw_y   = {req_y_high_byte[6:0], req_y_low_byte, 1'b0};
      raw_z   = {req_z_high_byte[6:0], req_z_low_byte, 1'b0};
      two_g   = {5'd0, one_g_ff, 1'b0};
      s1_x_in = CorrWidth'(raw_x) - CorrWidth'(offset_x_ff);
      s1_y_in = CorrWidth'(raw_y) - CorrWidth'(offset_y_ff);
      z_off   = CorrWidth'(raw_z) - CorrWidth'(offset_z_ff);
      case (gravity_mode_type'(gravity_ff))
         GRAV_SUB: s1_z_in = z_off - two_g;
         GRAV_ADD: s1_z_in = z_off + two_g;
         default:  s1_z_in = z_off;
      endcase
   end

   // Stage 2: zero x and y together inside the horizontal dead zone
   always_comb begin
      logic quiet;
      quiet = (s1_x_ff < DeadZone) && (s1_x_ff > -DeadZone) &&
              (s1_y_ff < DeadZone) && (s1_y_ff > -DeadZone);
      s2_x_in = quiet ? '0 : s1_x_ff;
      s2_y_in = quiet ? '0 : s1_y_ff;
   end

   // Stage 3: one remap row per output axis
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_sum_in[r] =
            SumWidth'(matrix_term(matrix_ff[6*r+1 -: 2], s2_x_ff)) +
            SumWidth'(matrix_term(matrix_ff[6*r+3 -: 2], s2_y_ff)) +
            SumWidth'(matrix_term(matrix_ff[6*r+5 -: 2], s2_z_ff));
      end
   end

   // Stage 4: scale each row
   always_comb begin
      logic signed [ProdWidth-1:0] prod;
      for (int r = 0; r < 3; r++) begin
         prod         = ProdWidth'(s3_sum_ff[r]) * Scale;
         s4_acc_in[r] = prod[AccelWidth-1:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_x_ff <= s1_x_in;
      s1_y_ff <= s1_y_in;
      s1_z_ff <= s1_z_in;
      s2_x_ff <= s2_x_in;
      s2_y_ff <= s2_y_in;
      s2_z_ff <= s1_z_ff;
      for (int r = 0; r < 3; r++) begin
         s3_sum_ff[r] <= s3_sum_in[r];
         s4_acc_ff[r] <= s4_acc_in[r];
      end
   end

   // Present the result word
   assign rsp_valid   = s4_valid_ff;
   assign rsp_accel_x = s4_acc_ff[0];
   assign rsp_accel_y = s4_acc_ff[1];
   assign rsp_accel_z = s4_acc_ff[2];

endmodule
